@@ src/jeo_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package jeo_pkg;

    // ring size limit
    localparam int JEO_MAX_PEOPLE = 64;

    // field widths fixed by the interface
    localparam int PERSON_W = 7;
    localparam int COUNT_W  = 7;
    localparam int STEP_W   = 9;
    localparam int MOVES_W  = 8;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERSON_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP         = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_SEEK,
        ST_WALK,
        ST_LOOKUP,
        ST_EMIT,
        ST_FINAL
    } jeo_state_t;

    // run settings captured at start
    typedef struct packed {
        logic               fwd;
        logic [MOVES_W-1:0] moves;
    } run_cfg_t;

    // result offered by the sequencer
    typedef struct packed {
        logic                valid;
        logic [PERSON_W-1:0] id;
        logic                last;
    } result_t;

endpackage

`default_nettype wire

@@ src/jeo_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jeo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ src/jeo_walker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module jeo_walker
    import jeo_pkg::*;
#(
    parameter int MAX_PEOPLE = JEO_MAX_PEOPLE
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic [$clog2(MAX_PEOPLE+1)-1:0]     n_in,
    input  wire run_cfg_t                            run_in,
    output logic                                     busy,
    output result_t                                  res,
    input  wire logic                                res_take
);

    localparam int IDX_W = $clog2(MAX_PEOPLE);
    localparam int CNT_W = $clog2(MAX_PEOPLE + 1);

    jeo_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   t_reg, t_next;
    logic [MOVES_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    run_cfg_t           run_reg, run_next;
    logic [PERSON_W-1:0] id_reg, id_next;

    // link memories
    logic               nx_we, pv_we;
    logic [IDX_W-1:0]   nx_waddr, pv_waddr, nx_wdata, pv_wdata;
    logic [IDX_W-1:0]   rd_addr, nx_rd, pv_rd;
    logic [IDX_W-1:0]   t_step;
    logic               init_last;

    jeo_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PEOPLE)) u_next_ram (
        .aclk    (aclk),
        .wr_en   (nx_we),
        .wr_addr (nx_waddr),
        .wr_data (nx_wdata),
        .rd_addr (rd_addr),
        .rd_data (nx_rd)
    );

    jeo_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PEOPLE)) u_prev_ram (
        .aclk    (aclk),
        .wr_en   (pv_we),
        .wr_addr (pv_waddr),
        .wr_data (pv_wdata),
        .rd_addr (rd_addr),
        .rd_data (pv_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            t_reg     <= '0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            n_reg     <= '0;
            run_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            t_reg     <= t_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            n_reg     <= n_next;
            run_reg   <= run_next;
        end
        id_reg <= id_next;
    end

    assign t_step    = run_reg.fwd ? nx_rd : pv_rd;
    assign init_last = (CNT_W'(idx_reg) + CNT_W'(1)) == n_reg;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        t_next     = t_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        n_next     = n_reg;
        run_next   = run_reg;
        id_next    = id_reg;
        nx_we      = 1'b0;
        pv_we      = 1'b0;
        nx_waddr   = idx_reg;
        pv_waddr   = idx_reg;
        nx_wdata   = '0;
        pv_wdata   = '0;
        rd_addr    = t_reg;
        res        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    n_next     = n_in;
                    run_next   = run_in;
                    idx_next   = '0;
                    state_next = ST_INIT;
                end
            end
            // build the ring, one index per cycle
            ST_INIT: begin
                nx_we    = 1'b1;
                pv_we    = 1'b1;
                nx_wdata = init_last ? '0 : IDX_W'(idx_reg + IDX_W'(1));
                pv_wdata = (idx_reg == '0) ? IDX_W'(n_reg - CNT_W'(1))
                                           : IDX_W'(idx_reg - IDX_W'(1));
                idx_next = IDX_W'(idx_reg + IDX_W'(1));
                if (init_last) begin
                    t_next   = '0;
                    rem_next = n_reg;
                    cnt_next = run_reg.moves;
                    state_next = (n_reg > CNT_W'(1)) ? ST_SEEK : ST_FINAL;
                end
            end
            ST_SEEK: begin
                rd_addr    = t_reg;
                state_next = (cnt_reg == '0) ? ST_LOOKUP : ST_WALK;
            end
            // one link per cycle
            ST_WALK: begin
                rd_addr  = t_step;
                t_next   = t_step;
                cnt_next = cnt_reg - MOVES_W'(1);
                if (cnt_reg == MOVES_W'(1)) begin
                    state_next = ST_LOOKUP;
                end
            end
            // both neighbors of t are on the read ports: unlink t
            ST_LOOKUP: begin
                nx_we      = 1'b1;
                nx_waddr   = pv_rd;
                nx_wdata   = nx_rd;
                pv_we      = 1'b1;
                pv_waddr   = nx_rd;
                pv_wdata   = pv_rd;
                id_next    = PERSON_W'(32'(t_reg) + 32'd1);
                t_next     = t_step;
                rem_next   = rem_reg - CNT_W'(1);
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                res.valid = 1'b1;
                res.id    = id_reg;
                res.last  = 1'b0;
                if (res_take) begin
                    cnt_next   = run_reg.moves;
                    state_next = (rem_reg > CNT_W'(1)) ? ST_SEEK : ST_FINAL;
                end
            end
            ST_FINAL: begin
                res.valid = 1'b1;
                res.id    = PERSON_W'(32'(t_reg) + 32'd1);
                res.last  = 1'b1;
                if (res_take) begin
                    rem_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

@@ src/josephus_elimination_order.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Josephus elimination order. A start transfer (s_tdata bit 0 set) builds a
// ring of people 1..person_count (0 read as 1, clamped to MAX_PEOPLE) and the
// block then sends one transfer per removed person, the survivor last with
// m_tlast set. A positive step counts forward step-1 places; a negative step
// counts backward |step|-1 places, and a zero step acts as -1. A start
// transfer with bit 0 clear is taken and dropped. The ring lives in two link
// memories (next and prev) with registered reads; the walk follows one link
// per cycle through the shared read address. A run first builds the ring,
// then for each removal seeks, makes moves link reads, unlinks and offers the
// person, and last offers the survivor; each offer waits for the output.
// The largest move count is 255, from step -256. s_tready is low for the
// whole run; the user must write configuration only while idle, which the
// block itself does not enforce.
module josephus_elimination_order
    import jeo_pkg::*;
#(
    parameter int MAX_PEOPLE = JEO_MAX_PEOPLE
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration writes
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [STEP_W-1:0]    cfg_wdata,
    // start channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [0] start_req, [7:1] zero
    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,   // [6:0] person_id, [7] zero
    output logic                      m_tlast
);

    localparam int CNT_W = $clog2(MAX_PEOPLE + 1);

    logic [COUNT_W-1:0]  person_count_reg;
    logic [STEP_W-1:0]   step_reg;

    logic                m_valid_reg;
    logic [PERSON_W-1:0] m_id_reg;
    logic                m_last_reg;

    logic                busy;
    logic                start;
    logic                res_take;
    result_t             res;
    logic [CNT_W-1:0]    n_start;
    run_cfg_t            run_start;
    logic [STEP_W-1:0]   step_neg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            person_count_reg <= COUNT_W'(1);
            step_reg         <= STEP_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PERSON_COUNT: person_count_reg <= cfg_wdata[COUNT_W-1:0];
                REG_STEP:         step_reg         <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // effective ring size: zero reads as one, clamp to the memory depth
    always_comb begin
        if (person_count_reg == '0) begin
            n_start = CNT_W'(1);
        end else if (32'(person_count_reg) > 32'(MAX_PEOPLE)) begin
            n_start = CNT_W'(MAX_PEOPLE);
        end else begin
            n_start = CNT_W'(person_count_reg);
        end
    end

    // direction and link moves per removal; zero step acts as -1
    assign step_neg = STEP_W'(0) - step_reg;
    always_comb begin
        run_start.fwd = !step_reg[STEP_W-1] && (step_reg != '0);
        if (run_start.fwd) begin
            run_start.moves = MOVES_W'(step_reg - STEP_W'(1));
        end else if (step_reg == '0) begin
            run_start.moves = '0;
        end else begin
            // most negative step wraps to 256 here, giving 255 moves
            run_start.moves = MOVES_W'(step_neg - STEP_W'(1));
        end
    end

    assign s_tready = !busy;
    assign start    = s_tvalid && s_tready && s_tdata[0];

    jeo_walker #(.MAX_PEOPLE(MAX_PEOPLE)) u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .n_in     (n_start),
        .run_in   (run_start),
        .busy     (busy),
        .res      (res),
        .res_take (res_take)
    );

    // output register: load when empty or when the held transfer completes
    assign res_take = res.valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_take) begin
            m_id_reg   <= res.id;
            m_last_reg <= res.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_id_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // after the survivor is handed over the sequencer is idle again
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_take && res.last |=> !busy)
        else $error("sequencer still busy after survivor");

    // an accepted start command begins a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy)
        else $error("start transfer did not begin a run");

    // an offered result holds until the output register takes it
    assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && !res_take |=> res.valid && $stable(res.id) && $stable(res.last))
        else $error("offered result changed before it was taken");

    // person numbers are never zero while they fit the field
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (MAX_PEOPLE <= 127) |-> m_tdata[6:0] != 7'd0)
        else $error("person number zero on result channel");
`endif

endmodule

`default_nettype wire
